### src/particle_integrate_bounce_assert.svh
// Assertion macros used by the particle update checker.
`ifndef PARTICLE_INTEGRATE_BOUNCE_ASSERT_SVH
`define PARTICLE_INTEGRATE_BOUNCE_ASSERT_SVH
// Same-cycle implication, disabled in reset.
`define PIB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled in reset.
`define PIB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
// Holds on the cycle after a reset edge.
`define PIB_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) else $error(msg);
`endif

### src/pib_pkg.sv
// Package: payload types, register indexes, reset values and fixed widths of the particle update.
package pib_pkg;

  localparam int FIELD_BITS    = 48;
  localparam int Q16_SHIFT     = 16;
  localparam int TS_BITS       = 32;
  localparam int LEN_BITS      = 47;
  localparam int FAC_BITS      = 17;
  localparam int CFG_DATA_BITS = 47;
  localparam int CFG_IDX_BITS  = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_TIME_STEP   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_EDGE_MARGIN = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_WORLD_SIZE  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOUNCE      = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_DRAG        = 3'd4;

  localparam logic [TS_BITS-1:0]  TS_RESET     = 32'd65536;
  localparam logic [LEN_BITS-1:0] MARGIN_RESET = 47'd327680;
  localparam logic [LEN_BITS-1:0] WORLD_RESET  = 47'd65536000;
  localparam logic [FAC_BITS-1:0] BOUNCE_RESET = 17'd45875;
  localparam logic [FAC_BITS-1:0] DRAG_RESET   = 17'd64881;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] pos_x;
    logic signed [FIELD_BITS-1:0] pos_y;
    logic signed [FIELD_BITS-1:0] vel_x;
    logic signed [FIELD_BITS-1:0] vel_y;
    logic signed [FIELD_BITS-1:0] spin;
    logic                         has_spin;
    logic                         asleep;
  } pib_in_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] new_pos_x;
    logic signed [FIELD_BITS-1:0] new_pos_y;
    logic signed [FIELD_BITS-1:0] new_vel_x;
    logic signed [FIELD_BITS-1:0] new_vel_y;
    logic signed [FIELD_BITS-1:0] new_spin;
  } pib_out_t;

endpackage

### src/pib_mul.sv
// Two-stage multi-lane unsigned multiplier built from four half-width partial products.
module pib_mul import pib_pkg::*; #(
  parameter int LANES = 1,
  parameter int AW    = 32,
  parameter int BW    = 32,
  parameter int SW    = 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [LANES-1:0][AW-1:0]        a,
  input  logic [LANES-1:0][BW-1:0]        b,
  input  logic [SW-1:0]                   in_side,
  output logic                            out_valid,
  output logic [LANES-1:0][AW+BW-1:0]     p,
  output logic [SW-1:0]                   out_side
);

  localparam int AL = AW / 2;
  localparam int AH = AW - AL;
  localparam int BL = BW / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic [LANES-1:0][AL+BL-1:0] ll_r;
  logic [LANES-1:0][AL+BH-1:0] lh_r;
  logic [LANES-1:0][AH+BL-1:0] hl_r;
  logic [LANES-1:0][AH+BH-1:0] hh_r;
  logic [LANES-1:0][PW-1:0]    p_r;
  logic [SW-1:0]               side1_r, side2_r;
  logic                        v1_r, v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        ll_r[i] <= a[i][AL-1:0]  * b[i][BL-1:0];
        lh_r[i] <= a[i][AL-1:0]  * b[i][BW-1:BL];
        hl_r[i] <= a[i][AW-1:AL] * b[i][BL-1:0];
        hh_r[i] <= a[i][AW-1:AL] * b[i][BW-1:BL];
        p_r[i]  <= PW'(ll_r[i]) + (PW'(lh_r[i]) << BL) + (PW'(hl_r[i]) << AL)
                 + (PW'(hh_r[i]) << (AL + BL));
      end
      side1_r <= in_side;
      side2_r <= side1_r;
    end
  end

  assign out_valid = v2_r;
  assign p         = p_r;
  assign out_side  = side2_r;

endmodule

### src/pib_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module pib_sqrt import pib_pkg::*; #(
  parameter int W  = 48,
  parameter int SW = 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  logic [2*W-1:0] s,
  input  logic [SW-1:0]  in_side,
  output logic           out_valid,
  output logic [W-1:0]   root,
  output logic [SW-1:0]  out_side
);

  localparam int RW = W + 3;

  logic           v_r    [W];
  logic [RW-1:0]  rem_r  [W];
  logic [W-1:0]   root_r [W];
  logic [2*W-1:0] sh_r   [W];
  logic [SW-1:0]  side_r [W];

  for (genvar k = 0; k < W; k++) begin : g_st
    logic           cv;
    logic [RW-1:0]  crem;
    logic [W-1:0]   croot;
    logic [2*W-1:0] cs;
    logic [SW-1:0]  cside;
    logic [RW-1:0]  x, t;
    logic           ge;

    if (k == 0) begin : g_in
      assign cv    = in_valid;
      assign crem  = '0;
      assign croot = '0;
      assign cs    = s;
      assign cside = in_side;
    end else begin : g_mid
      assign cv    = v_r[k-1];
      assign crem  = rem_r[k-1];
      assign croot = root_r[k-1];
      assign cs    = sh_r[k-1];
      assign cside = side_r[k-1];
    end

    assign x  = {crem[RW-3:0], cs[2*W-1 -: 2]};
    assign t  = RW'({croot, 2'b01});
    assign ge = (x >= t);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= cv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? (x - t) : x;
        root_r[k] <= {croot[W-2:0], ge};
        sh_r[k]   <= cs << 2;
        side_r[k] <= cside;
      end
    end
  end

  assign out_valid = v_r[W-1];
  assign root      = root_r[W-1];
  assign out_side  = side_r[W-1];

endmodule

### src/pib_div.sv
// Pipelined restoring divider, one quotient bit per stage; needs dividend <= divisor.
module pib_div import pib_pkg::*; #(
  parameter int LANES = 2,
  parameter int W     = 48,
  parameter int QB    = 17,
  parameter int SW    = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [LANES-1:0][W-1:0]    m,
  input  logic [W-1:0]               d,
  input  logic [SW-1:0]              in_side,
  output logic                       out_valid,
  output logic [LANES-1:0][QB-1:0]   q,
  output logic [SW-1:0]              out_side
);

  logic                     v_r    [QB];
  logic [LANES-1:0][W:0]    rem_r  [QB];
  logic [LANES-1:0][QB-1:0] q_r    [QB];
  logic [W-1:0]             d_r    [QB];
  logic [SW-1:0]            side_r [QB];

  for (genvar k = 0; k < QB; k++) begin : g_st
    logic                     cv;
    logic [LANES-1:0][W:0]    cx;
    logic [LANES-1:0][QB-1:0] cq;
    logic [W-1:0]             cd;
    logic [SW-1:0]            cside;

    if (k == 0) begin : g_in
      assign cv    = in_valid;
      assign cd    = d;
      assign cq    = '0;
      assign cside = in_side;
      always_comb begin
        for (int i = 0; i < LANES; i++) cx[i] = {1'b0, m[i]};
      end
    end else begin : g_mid
      assign cv    = v_r[k-1];
      assign cd    = d_r[k-1];
      assign cq    = q_r[k-1];
      assign cside = side_r[k-1];
      always_comb begin
        for (int i = 0; i < LANES; i++) cx[i] = {rem_r[k-1][i][W-1:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= cv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < LANES; i++) begin
          if (cx[i] >= {1'b0, cd}) begin
            rem_r[k][i] <= cx[i] - {1'b0, cd};
            q_r[k][i]   <= {cq[i][QB-2:0], 1'b1};
          end else begin
            rem_r[k][i] <= cx[i];
            q_r[k][i]   <= {cq[i][QB-2:0], 1'b0};
          end
        end
        d_r[k]    <= cd;
        side_r[k] <= cside;
      end
    end
  end

  assign out_valid = v_r[QB-1];
  assign q         = q_r[QB-1];
  assign out_side  = side_r[QB-1];

endmodule

### src/particle_integrate_bounce.sv
// Top level: pipelined Euler particle step, wall clamp, bounce with unit-speed limit, drag.
//
//   port group | dir | handshake            | beat
//   in_        | in  | in_valid / in_ready  | pib_in_t particle
//   out_       | out | out_valid / out_ready| pib_out_t updated particle
//   cfg_       | in  | cfg_we               | register cfg_index <- cfg_wdata
//
// One beat enters per cycle while in_ready is high; the pipeline contains the square-root
// stages (one per root bit) and the divider stages (one per quotient bit). A two-entry
// output buffer takes results; the whole pipeline holds only while both entries are full.
// Reset clears valid bits and the buffer and loads the register defaults.
module particle_integrate_bounce import pib_pkg::*; #(
  parameter int WORD_BITS = 48,
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  pib_in_t                  in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output pib_out_t                 out_data,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int FB  = FIELD_BITS;
  localparam int BX  = ((W > FB) ? W : FB) + 1;
  localparam int PW  = W + TS_BITS;
  localparam int DW  = W + FAC_BITS;
  localparam int SWD = (2 * W > 2 * F) ? 2 * W : 2 * F + 1;
  localparam int QB  = F + 1;

  typedef logic [W-1:0] word_t;

  typedef struct packed {
    pib_in_t raw;
    word_t   px, py, vx, vy, sp;
  } s1_t;

  typedef struct packed {
    pib_in_t raw;
    word_t   px, py, vx, vy, dx, dy, bmx, bmy, spd;
    logic    bovx, bovy;
  } s3_t;

  typedef struct packed {
    pib_in_t raw;
    word_t   px, py, vx, vy, spd;
    logic    flag;
  } s5_t;

  localparam word_t            WMAX   = {1'b0, {(W-1){1'b1}}};
  localparam word_t            WMIN   = {1'b1, {(W-1){1'b0}}};
  localparam logic [BX-1:0]    BMAX   = BX'(WMAX);
  localparam logic [BX-1:0]    BMIN   = ~BMAX;
  localparam logic [PW-1:0]    LIMP   = PW'(WMAX);
  localparam logic [SWD-1:0]   NORM_T = SWD'(1) << (2 * F);

  function automatic word_t clamp_w(input logic [BX-1:0] e);
    word_t r;
    if ($signed(e) > $signed(BMAX))      r = WMAX;
    else if ($signed(e) < $signed(BMIN)) r = WMIN;
    else                                 r = e[W-1:0];
    return r;
  endfunction

  function automatic word_t from_field(input logic [FB-1:0] raw);
    return clamp_w(BX'($signed(raw)));
  endfunction

  function automatic logic [FB-1:0] to_field(input word_t v);
    return FB'($signed(v));
  endfunction

  function automatic word_t mag(input word_t v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic word_t sat(input logic neg, input logic [PW-1:0] m);
    word_t r;
    if (m > LIMP)  r = neg ? WMIN : WMAX;
    else if (neg)  r = ~m[W-1:0] + 1'b1;
    else           r = m[W-1:0];
    return r;
  endfunction

  function automatic word_t add_sat(input word_t a, input word_t b);
    logic [W:0] s;
    word_t      r;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) r = s[W] ? WMIN : WMAX;
    else                r = s[W-1:0];
    return r;
  endfunction

  // configuration
  logic [TS_BITS-1:0]  ts_r;
  logic [LEN_BITS-1:0] margin_r, world_r;
  logic [FAC_BITS-1:0] bf_r, df_r;
  word_t               lo_r, hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r     <= TS_RESET;
      margin_r <= MARGIN_RESET;
      world_r  <= WORLD_RESET;
      bf_r     <= BOUNCE_RESET;
      df_r     <= DRAG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TIME_STEP:   ts_r     <= cfg_wdata[TS_BITS-1:0];
        REG_EDGE_MARGIN: margin_r <= cfg_wdata[LEN_BITS-1:0];
        REG_WORLD_SIZE:  world_r  <= cfg_wdata[LEN_BITS-1:0];
        REG_BOUNCE:      bf_r     <= cfg_wdata[FAC_BITS-1:0];
        REG_DRAG:        df_r     <= cfg_wdata[FAC_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= clamp_w(BX'(margin_r));
    hi_r <= clamp_w(BX'(world_r) - BX'(margin_r));
  end

  // pipeline advance
  logic [1:0] cnt_r, cnt_nxt;
  logic       en;
  assign en       = (cnt_r != 2'd2);
  assign in_ready = en;

  // stage 0: input register
  logic    v0_r;
  pib_in_t d0_r;

  always_ff @(posedge clk) begin
    if (!rst_n)  v0_r <= 1'b0;
    else if (en) v0_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) d0_r <= in_data;
  end

  s1_t                 s1;
  logic [4:0][W-1:0]   m1_a;
  logic [4:0][TS_BITS-1:0] m1_b;

  always_comb begin
    s1.raw  = d0_r;
    s1.px   = from_field(d0_r.pos_x);
    s1.py   = from_field(d0_r.pos_y);
    s1.vx   = from_field(d0_r.vel_x);
    s1.vy   = from_field(d0_r.vel_y);
    s1.sp   = from_field(d0_r.spin);
    m1_a[0] = mag(s1.vx);
    m1_a[1] = mag(s1.vy);
    m1_a[2] = mag(s1.vx);
    m1_a[3] = mag(s1.vy);
    m1_a[4] = mag(s1.sp);
    m1_b[0] = ts_r;
    m1_b[1] = ts_r;
    m1_b[2] = TS_BITS'(bf_r);
    m1_b[3] = TS_BITS'(bf_r);
    m1_b[4] = TS_BITS'(df_r);
  end

  // step, bounce and spin products
  logic              m1_v;
  logic [4:0][PW-1:0] m1_p;
  s1_t               m1_s;

  pib_mul #(.LANES(5), .AW(W), .BW(TS_BITS), .SW($bits(s1_t))) u_mul_step (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v0_r), .a(m1_a), .b(m1_b), .in_side(s1),
    .out_valid(m1_v), .p(m1_p), .out_side(m1_s)
  );

  // stages 3 to 5: scale and saturate, add the step to the position, register the wall result
  logic v3_r, v4_r, v5_r;
  s3_t  s3_r, s4_r, s4_nxt;
  s5_t  s5_r, s5_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v3_r <= m1_v;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_comb begin
    s4_nxt    = s3_r;
    s4_nxt.px = add_sat(s3_r.px, s3_r.dx);
    s4_nxt.py = add_sat(s3_r.py, s3_r.dy);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r.raw  <= m1_s.raw;
      s3_r.px   <= m1_s.px;
      s3_r.py   <= m1_s.py;
      s3_r.vx   <= m1_s.vx;
      s3_r.vy   <= m1_s.vy;
      s3_r.dx   <= sat(m1_s.vx[W-1], m1_p[0] >> F);
      s3_r.dy   <= sat(m1_s.vy[W-1], m1_p[1] >> F);
      s3_r.bmx  <= sat(1'b0, m1_p[2] >> Q16_SHIFT);
      s3_r.bmy  <= sat(1'b0, m1_p[3] >> Q16_SHIFT);
      s3_r.bovx <= ((m1_p[2] >> Q16_SHIFT) > LIMP);
      s3_r.bovy <= ((m1_p[3] >> Q16_SHIFT) > LIMP);
      s3_r.spd  <= sat(m1_s.sp[W-1], m1_p[4] >> Q16_SHIFT);

      s4_r <= s4_nxt;

      s5_r <= s5_nxt;
    end
  end

  // stage 5: wall clamp and reflection; low wall tested first
  always_comb begin
    logic bx, by;
    s5_nxt.raw = s4_r.raw;
    s5_nxt.spd = s4_r.spd;
    s5_nxt.px  = s4_r.px;
    s5_nxt.vx  = s4_r.vx;
    s5_nxt.py  = s4_r.py;
    s5_nxt.vy  = s4_r.vy;
    bx = 1'b0;
    by = 1'b0;
    if ($signed(s4_r.px) < $signed(lo_r)) begin
      s5_nxt.px = lo_r;
      s5_nxt.vx = s4_r.bmx;
      bx = 1'b1;
    end else if ($signed(s4_r.px) > $signed(hi_r)) begin
      s5_nxt.px = hi_r;
      s5_nxt.vx = s4_r.bovx ? WMIN : (~s4_r.bmx + 1'b1);
      bx = 1'b1;
    end
    if ($signed(s4_r.py) < $signed(lo_r)) begin
      s5_nxt.py = lo_r;
      s5_nxt.vy = s4_r.bmy;
      by = 1'b1;
    end else if ($signed(s4_r.py) > $signed(hi_r)) begin
      s5_nxt.py = hi_r;
      s5_nxt.vy = s4_r.bovy ? WMIN : (~s4_r.bmy + 1'b1);
      by = 1'b1;
    end
    s5_nxt.flag = bx | by;
  end

  // squared speed
  logic [1:0][W-1:0]   m2_a;
  logic                m2_v;
  logic [1:0][2*W-1:0] m2_p;
  s5_t                 m2_s;

  always_comb begin
    m2_a[0] = mag(s5_r.vx);
    m2_a[1] = mag(s5_r.vy);
  end

  pib_mul #(.LANES(2), .AW(W), .BW(W), .SW($bits(s5_t))) u_mul_sq (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v5_r), .a(m2_a), .b(m2_a), .in_side(s5_r),
    .out_valid(m2_v), .p(m2_p), .out_side(m2_s)
  );

  // stage 6: sum and normalize decision
  logic           v6_r;
  s5_t            s6_r, s6_nxt;
  logic [2*W-1:0] sum6_r;
  logic [2*W-1:0] sum;

  assign sum = m2_p[0] + m2_p[1];

  always_comb begin
    s6_nxt      = m2_s;
    s6_nxt.flag = m2_s.flag && (SWD'(sum) > NORM_T);
  end

  always_ff @(posedge clk) begin
    if (!rst_n)  v6_r <= 1'b0;
    else if (en) v6_r <= m2_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_r   <= s6_nxt;
      sum6_r <= sum;
    end
  end

  // speed root and unit-vector divide
  logic  sq_v;
  word_t sq_root;
  s5_t   sq_s;

  pib_sqrt #(.W(W), .SW($bits(s5_t))) u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v6_r), .s(sum6_r), .in_side(s6_r),
    .out_valid(sq_v), .root(sq_root), .out_side(sq_s)
  );

  logic [1:0][W-1:0]  dv_m;
  logic               dv_v;
  logic [1:0][QB-1:0] dv_q;
  s5_t                dv_s;

  always_comb begin
    dv_m[0] = mag(sq_s.vx);
    dv_m[1] = mag(sq_s.vy);
  end

  pib_div #(.LANES(2), .W(W), .QB(QB), .SW($bits(s5_t))) u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(sq_v), .m(dv_m), .d(sq_root), .in_side(sq_s),
    .out_valid(dv_v), .q(dv_q), .out_side(dv_s)
  );

  // stage 7: apply unit vector
  logic v7_r;
  s5_t  s7_r, s7_nxt;

  always_comb begin
    s7_nxt = dv_s;
    if (dv_s.flag) begin
      s7_nxt.vx = sat(dv_s.vx[W-1], PW'(dv_q[0]));
      s7_nxt.vy = sat(dv_s.vy[W-1], PW'(dv_q[1]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)  v7_r <= 1'b0;
    else if (en) v7_r <= dv_v;
  end

  always_ff @(posedge clk) begin
    if (en) s7_r <= s7_nxt;
  end

  // drag
  logic [1:0][W-1:0]      m3_a;
  logic [1:0][FAC_BITS-1:0] m3_b;
  logic                   m3_v;
  logic [1:0][DW-1:0]     m3_p;
  s5_t                    m3_s;

  always_comb begin
    m3_a[0] = mag(s7_r.vx);
    m3_a[1] = mag(s7_r.vy);
    m3_b[0] = df_r;
    m3_b[1] = df_r;
  end

  pib_mul #(.LANES(2), .AW(W), .BW(FAC_BITS), .SW($bits(s5_t))) u_mul_drag (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v7_r), .a(m3_a), .b(m3_b), .in_side(s7_r),
    .out_valid(m3_v), .p(m3_p), .out_side(m3_s)
  );

  pib_out_t res;

  always_comb begin
    if (m3_s.raw.asleep) begin
      res.new_pos_x = m3_s.raw.pos_x;
      res.new_pos_y = m3_s.raw.pos_y;
      res.new_vel_x = m3_s.raw.vel_x;
      res.new_vel_y = m3_s.raw.vel_y;
      res.new_spin  = m3_s.raw.spin;
    end else begin
      res.new_pos_x = to_field(m3_s.px);
      res.new_pos_y = to_field(m3_s.py);
      res.new_vel_x = to_field(sat(m3_s.vx[W-1], PW'(m3_p[0] >> Q16_SHIFT)));
      res.new_vel_y = to_field(sat(m3_s.vy[W-1], PW'(m3_p[1] >> Q16_SHIFT)));
      res.new_spin  = m3_s.raw.has_spin ? to_field(m3_s.spd) : m3_s.raw.spin;
    end
  end

  // output buffer
  pib_out_t fifo_r [2];
  logic     wr_r, rd_r;
  logic     push, pop;

  assign push = m3_v & en;
  assign pop  = out_valid & out_ready;

  always_comb begin
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= ~wr_r;
      if (pop)  rd_r <= ~rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo_r[wr_r] <= res;
  end

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = fifo_r[rd_r];

endmodule

### src/pib_checker.sv
// Port-level checker for the particle update block, bound to the top level.
`include "particle_integrate_bounce_assert.svh"

module pib_checker import pib_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input pib_out_t out_data
);

  `PIB_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled beat changed")
  `PIB_ASSERT_IMP(a_stall_cause, !in_ready, out_valid, "input stalled with no result waiting")
  `PIB_ASSERT_IMP(a_stall_entry, $fell(in_ready), $past(out_valid && !out_ready), "input stalled without a blocked result")
  `PIB_ASSERT_RST(a_reset_clear, !out_valid && in_ready, "reset left output valid or input stalled")

endmodule

bind particle_integrate_bounce pib_checker u_pib_checker (.*);
